FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bitmap decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap decoder package
// Types and constants shared by the front parser and the pixel back end.
// ----------------------------------------------------------------------------
package bmp_pkg;

	localparam int unsigned DefMaxDimension = 16384;
	localparam longint unsigned DefMaxFileBytes = 64'd134217728;

	localparam logic [7:0] ChB = 8'h42;
	localparam logic [7:0] ChM = 8'h4D;
	localparam int unsigned HdrBytes = 54;

	localparam logic [2:0] StPixel = 3'd0;
	localparam logic [2:0] StBadSig = 3'd1;
	localparam logic [2:0] StBadSize = 3'd2;
	localparam logic [2:0] StFormat = 3'd3;
	localparam logic [2:0] StTooLarge = 3'd4;
	localparam logic [2:0] StOverrun = 3'd5;

	typedef enum logic [3:0] {
		PH_START, PH_GOT_B, PH_HUNT, PH_HUNT_B, PH_HEADER, PH_CHK1, PH_CHK2,
		PH_CHK3, PH_GAP, PH_PIXELS, PH_TAIL
	} phase_t;

	// One queue entry: a pixel byte, or a new-image/error marker.
	typedef struct packed {
		logic        is_err;
		logic [2:0]  err;
		logic        new_img;
		logic [7:0]  data;
	} cmd_t;

	// Image geometry fixed at header time.
	typedef struct packed {
		logic [16:0] width;
		logic [16:0] height;
		logic        top_down;
		logic        four_bpp;
		logic [18:0] pad_bytes;
	} geom_t;

	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [13:0] column;
		logic [13:0] row;
		logic [14:0] image_width;
		logic [14:0] image_height;
		logic        frame_last;
		logic [2:0]  status;
	} res_t;

endpackage

FILE: rtl/bmp_front.sv
// ----------------------------------------------------------------------------
// Bitmap header parser
// Takes stream bytes, checks the header and passes pixel bytes, new-image and
// error markers into the command queue.
// ----------------------------------------------------------------------------
module bmp_front import bmp_pkg::*; #(
	parameter int unsigned MaxDimension = DefMaxDimension,
	parameter longint unsigned MaxFileBytes = DefMaxFileBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd,
	output geom_t       geom
);

	phase_t phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] fsize_q, offs_q, dib_q, wid_q, hgt_q, comp_q;
	logic [15:0] planes_q, bpp_q;
	logic [31:0] ahgt_q;
	logic [31:0] ahgt_w;
	logic [18:0] padrow_q;
	logic [35:0] prod_q;
	logic [1:0]  bsel;
	logic        stall;

	geom_t geom_q;
	assign geom = geom_q;

	// Check passes are internal and take no input byte.
	assign stall = (phase_q == PH_CHK1) || (phase_q == PH_CHK2) || (phase_q == PH_CHK3);
	assign in_ready = !stall && cmd_ready;

	logic        acc;
	assign acc = in_valid && in_ready;

	logic [31:0] bits_w;
	assign bits_w = wid_q[15:0] * bpp_q[5:0];

	assign ahgt_w = hgt_q[31] ? (32'd0 - hgt_q) : hgt_q;
	assign bsel = pos_q[1:0] - 2'd2;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		cmd = '0;
		cmd.data = data_byte;
		cmd_valid = 1'b0;
		case (phase_q)
			PH_START: if (acc) begin
				if (data_byte == ChB) phase_d = PH_GOT_B;
				else begin
					cmd_valid = 1'b1; cmd.is_err = 1'b1; cmd.err = StBadSig;
					phase_d = PH_HUNT;
				end
			end
			PH_GOT_B: if (acc) begin
				if (data_byte == ChM) begin
					phase_d = PH_HEADER; pos_d = 32'd2;
				end else begin
					cmd_valid = 1'b1; cmd.is_err = 1'b1; cmd.err = StBadSig;
					phase_d = PH_HUNT;
				end
			end
			PH_HUNT: if (acc && data_byte == ChB) phase_d = PH_HUNT_B;
			PH_HUNT_B: if (acc) begin
				if (data_byte == ChM) begin
					phase_d = PH_HEADER; pos_d = 32'd2;
				end else if (data_byte != ChB) phase_d = PH_HUNT;
			end
			PH_HEADER: if (acc) begin
				pos_d = pos_q + 32'd1;
				if (pos_q == 32'd13) begin
					if (fsize_q < 32'(HdrBytes) || 64'(fsize_q) > MaxFileBytes
						|| {data_byte, offs_q[23:0]} < 32'(HdrBytes)
						|| {data_byte, offs_q[23:0]} >= fsize_q) begin
						cmd_valid = 1'b1; cmd.is_err = 1'b1; cmd.err = StBadSize;
						phase_d = PH_HUNT;
					end
				end
				if (pos_q == 32'd53) phase_d = PH_CHK1;
			end
			PH_CHK1: begin
				if (dib_q < 32'd40 || wid_q == '0 || wid_q[31] || hgt_q == '0
					|| planes_q != 16'd1 || (bpp_q != 16'd24 && bpp_q != 16'd32)
					|| (comp_q != 32'd0 && comp_q != 32'd3)) begin
					cmd_valid = 1'b1; cmd.is_err = 1'b1; cmd.err = StFormat;
				end else if (64'(wid_q) > 64'(MaxDimension)
					|| 64'(ahgt_w) > 64'(MaxDimension)) begin
					cmd_valid = 1'b1; cmd.is_err = 1'b1; cmd.err = StTooLarge;
				end
				if (cmd_valid) begin
					if (cmd_ready) phase_d = PH_HUNT;
				end else phase_d = PH_CHK2;
			end
			PH_CHK2: phase_d = PH_CHK3;
			PH_CHK3: begin
				if (64'(offs_q) + 64'(prod_q) > 64'(fsize_q)) begin
					cmd_valid = 1'b1; cmd.is_err = 1'b1; cmd.err = StOverrun;
					if (cmd_ready) phase_d = PH_HUNT;
				end else begin
					cmd_valid = 1'b1; cmd.new_img = 1'b1;
					if (cmd_ready) begin
						pos_d = 32'd54;
						phase_d = (offs_q == 32'd54) ? PH_PIXELS : PH_GAP;
					end
				end
			end
			PH_GAP: if (acc) begin
				if (33'(pos_q) + 33'd1 >= 33'(offs_q)) phase_d = PH_PIXELS;
				pos_d = pos_q + 32'd1;
			end
			PH_PIXELS: if (acc) begin
				cmd_valid = 1'b1;
				pos_d = pos_q + 32'd1;
				if (33'(pos_q) + 33'd1 >= 33'(offs_q) + 33'(prod_q[31:0]))
					phase_d = (33'(pos_q) + 33'd1 >= 33'(fsize_q)) ? PH_START : PH_TAIL;
			end
			PH_TAIL: if (acc) begin
				if (33'(pos_q) + 33'd1 >= 33'(fsize_q)) phase_d = PH_START;
				pos_d = pos_q + 32'd1;
			end
			default: phase_d = PH_START;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pos_q <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_GOT_B || phase_q == PH_HUNT_B) begin
			fsize_q <= '0; offs_q <= '0; dib_q <= '0; wid_q <= '0;
			hgt_q <= '0; comp_q <= '0; planes_q <= '0; bpp_q <= '0;
		end
		if (phase_q == PH_HEADER && acc) begin
			if (pos_q >= 2 && pos_q <= 5) fsize_q[{bsel, 3'd0} +: 8] <= data_byte;
			if (pos_q >= 10 && pos_q <= 13) offs_q[{bsel, 3'd0} +: 8] <= data_byte;
			if (pos_q >= 14 && pos_q <= 17) dib_q[{bsel, 3'd0} +: 8] <= data_byte;
			if (pos_q >= 18 && pos_q <= 21) wid_q[{bsel, 3'd0} +: 8] <= data_byte;
			if (pos_q >= 22 && pos_q <= 25) hgt_q[{bsel, 3'd0} +: 8] <= data_byte;
			if (pos_q >= 26 && pos_q <= 27) planes_q[{pos_q[0], 3'd0} +: 8] <= data_byte;
			if (pos_q >= 28 && pos_q <= 29) bpp_q[{pos_q[0], 3'd0} +: 8] <= data_byte;
			if (pos_q >= 30 && pos_q <= 33) comp_q[{bsel, 3'd0} +: 8] <= data_byte;
		end
		if (phase_q == PH_CHK1) begin
			ahgt_q <= ahgt_w;
			padrow_q <= 19'(((bits_w + 32'd31) >> 5) << 2);
		end
		if (phase_q == PH_CHK2) begin
			prod_q <= 36'(padrow_q) * 36'(ahgt_q[16:0]);
			geom_q.width <= wid_q[16:0];
			geom_q.height <= ahgt_q[16:0];
			geom_q.top_down <= hgt_q[31];
			geom_q.four_bpp <= bpp_q[3] ? 1'b0 : 1'b1;
			geom_q.pad_bytes <= padrow_q;
		end
	end

endmodule

FILE: rtl/bmp_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the parser and the pixel back end.
// ----------------------------------------------------------------------------
module bmp_fifo import bmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	cmd_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data = mem_q[rp_q];

	logic wr, rd;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end

endmodule

FILE: rtl/bmp_back.sv
// ----------------------------------------------------------------------------
// Pixel back end
// Assembles pixel bytes into BGRA results, drops row padding and passes
// error markers out as error results.
// ----------------------------------------------------------------------------
module bmp_back import bmp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_ready,
	input  cmd_t  cmd,
	input  geom_t geom,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	`include "assert_macros.svh"

	logic [18:0] rbc_q;
	logic [13:0] col_q;
	logic [16:0] row_q;
	logic [1:0]  idx_q;
	logic [15:0] part_q;
	logic [18:0] data_bytes;
	logic        take, emit;
	geom_t       geom_q;
	res_t        r;

	assign cmd_ready = !res_valid || res_ready;
	assign take = cmd_valid && cmd_ready;
	assign data_bytes = geom_q.four_bpp ? {geom_q.width, 2'b00}
		: (19'(geom_q.width) + {geom_q.width, 1'b0});

	always_comb begin
		r = '0;
		emit = 1'b0;
		if (cmd.is_err) begin
			emit = 1'b1;
			r.status = cmd.err;
		end else if (!cmd.new_img && rbc_q < data_bytes && idx_q == 2'd2) begin
			emit = 1'b1;
			r.blue = part_q[7:0];
			r.green = part_q[15:8];
			r.red = cmd.data;
			r.alpha = 8'hFF;
			r.column = col_q;
			r.row = geom_q.top_down ? row_q[13:0] : 14'(geom_q.height - 17'd1 - row_q);
			r.image_width = geom_q.width[14:0];
			r.image_height = geom_q.height[14:0];
			r.frame_last = (17'(col_q) + 17'd1 == geom_q.width)
				&& (row_q + 17'd1 == geom_q.height);
			r.status = StPixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbc_q <= '0; col_q <= '0; row_q <= '0; idx_q <= '0;
			geom_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			if (take) begin
				if (emit) res_valid <= 1'b1;
				if (cmd.new_img) begin
					rbc_q <= '0; col_q <= '0; row_q <= '0; idx_q <= '0;
					geom_q <= geom;
				end else if (!cmd.is_err) begin
					if (rbc_q + 19'd1 >= geom_q.pad_bytes) begin
						rbc_q <= '0; col_q <= '0; idx_q <= '0;
						row_q <= row_q + 17'd1;
					end else begin
						rbc_q <= rbc_q + 19'd1;
						if (rbc_q < data_bytes) begin
							if (idx_q == (geom_q.four_bpp ? 2'd3 : 2'd2)) begin
								idx_q <= '0;
								col_q <= col_q + 14'd1;
							end else idx_q <= idx_q + 2'd1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !cmd.is_err && !cmd.new_img) begin
			if (idx_q == 2'd0) part_q[7:0] <= cmd.data;
			if (idx_q == 2'd1) part_q[15:8] <= cmd.data;
		end
		if (take && emit) res <= r;
	end

	`ASSERT_NEXT(a_emit_valid, clk, arst_n, take && emit, res_valid)
	`ASSERT_IMPL(a_idx_range, clk, arst_n, !geom_q.four_bpp && res_valid, idx_q != 2'd3)
	`ASSERT_IMPL(a_err_zero, clk, arst_n, res_valid && res.status != StPixel, res.alpha == 8'd0)

endmodule

FILE: rtl/bmp_stream_to_bgra.sv
// ----------------------------------------------------------------------------
// BMP stream to BGRA
// Decodes back-to-back 24 and 32 bpp bitmap files into BGRA pixels.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// in      | in_valid/in_ready  | data_byte
// out     | out_valid/out_ready| blue green red alpha column row image_width
//         |                    | image_height frame_last status
// One byte is taken per cycle while the four-entry queue has room and the
// parser is not checking. The byte that causes a result enters the queue,
// and the result register is loaded from the queue head once it is free.
// After header byte 53 the parser runs checks and the row-size product in
// states CHK1 to CHK3, taking no bytes, and waits while the queue is full.
// Reset clears all control state; a stalled output fills the queue and then
// stops input.
module bmp_stream_to_bgra import bmp_pkg::*; #(
	parameter int unsigned MaxDimension = DefMaxDimension,
	parameter longint unsigned MaxFileBytes = DefMaxFileBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  blue,
	output logic [7:0]  green,
	output logic [7:0]  red,
	output logic [7:0]  alpha,
	output logic [13:0] column,
	output logic [13:0] row,
	output logic [14:0] image_width,
	output logic [14:0] image_height,
	output logic        frame_last,
	output logic [2:0]  status
);

	cmd_t  f_cmd, b_cmd;
	logic  f_valid, f_ready, b_valid, b_ready;
	geom_t geom;
	res_t  res;

	bmp_front #(.MaxDimension(MaxDimension), .MaxFileBytes(MaxFileBytes)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd), .geom
	);

	bmp_fifo u_fifo (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	bmp_back u_back (
		.clk, .arst_n, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd), .geom,
		.res_valid(out_valid), .res_ready(out_ready), .res
	);

	assign blue = res.blue;
	assign green = res.green;
	assign red = res.red;
	assign alpha = res.alpha;
	assign column = res.column;
	assign row = res.row;
	assign image_width = res.image_width;
	assign image_height = res.image_height;
	assign frame_last = res.frame_last;
	assign status = res.status;

endmodule
